### sv/assert_macros.svh
// Assertion helpers; clk_i and rst_ni must exist in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/bbms_pkg.sv
package bbms_pkg;

  localparam int FT_W   = 16;
  localparam int MOUSE_W = 16;
  localparam int POS_W  = 32;
  localparam int SCR_W  = 12;
  localparam int RAD_W  = 11;
  localparam int FAC_W  = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_BALL_RADIUS   = 3'd2,
    CFG_FRICTION      = 3'd3,
    CFG_BOUNCE        = 3'd4
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_HIT,
    ST_SQY,
    ST_SQR,
    ST_HITDEC,
    ST_BRANCH,
    ST_DRAG,
    ST_MOVE,
    ST_MVY,
    ST_WX,
    ST_WXB,
    ST_WY,
    ST_WYB,
    ST_FX,
    ST_FY,
    ST_FIN,
    ST_OUT,
    ST_WAIT
  } state_e;

endpackage

### sv/bouncing_ball_motion_step.sv
// Bouncing ball, one Euler step per frame item. Positions and velocities are
// signed fixed point with FRAC_BITS fraction bits in 32 bits, saturating.
// A press inside the ball starts a drag; a release (without a press) ends it.
// All products run through one shift-add multiplier. It takes one bit of the
// multiplier operand per cycle and stops once the remaining bits are zero.
// A product takes its issuing state and then waits on the multiplier in
// ST_WAIT. A free-flight frame uses four to six products with 16-bit
// operands (frame time, friction, bounce). A press adds the hit test: three
// squares of 11+FRAC_BITS bits, skipped when the pointer is clearly outside
// the ball. A drag frame skips the multiplier. The worst item is a press
// with no hit followed by free flight. One item is in work at a time; a
// finished result waits in the output register while the next item is
// accepted, and the sequencer holds in its output state while that register
// is full and not being taken. Configuration writes are taken at any time
// but are meant for idle periods; unknown indexes are dropped.
`include "assert_macros.svh"

module bouncing_ball_motion_step
  import bbms_pkg::*;
#(
  parameter int FRAC_BITS  = 16,
  parameter int MOUSE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // frame in
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [47:0]          s_axis_tdata,  // frame_time, mouse_x, mouse_y
  input  logic [1:0]           s_axis_tuser,  // button_pressed, button_released
  // result out
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [127:0]         m_axis_tdata,  // ball_x, ball_y, speed_x, speed_y
  output logic                 m_axis_tuser,  // held
  // configuration write
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  localparam int RW = RAD_W + FRAC_BITS;          // fixed-point radius width
  localparam int AW = (RW + 1 > 33) ? RW + 1 : 33;
  localparam int BW = RW;
  localparam int PW = AW + BW;
  localparam int WW = PW + 1;

  typedef logic signed [WW-1:0] wide_t;

  localparam wide_t MAXV = wide_t'(2147483647);
  localparam wide_t MINV = -MAXV - wide_t'(1);

  function automatic logic signed [POS_W-1:0] sat32(input wide_t v);
    logic signed [POS_W-1:0] r;
    if (v > MAXV) begin
      r = MAXV[POS_W-1:0];
    end else if (v < MINV) begin
      r = MINV[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  // Q0.16 product rounding: floor((p + 2^15) / 2^16)
  function automatic wide_t rnd16(input logic signed [PW-1:0] p);
    wide_t t;
    t = wide_t'(p) + wide_t'(32768);
    return t >>> 16;
  endfunction

  // config registers
  logic [SCR_W-1:0] width_q, height_q;
  logic [RAD_W-1:0] radius_q;
  logic [FAC_W-1:0] fric_q, bounce_q;

  // ball state
  logic signed [POS_W-1:0]      cx_q, cy_q, vx_q, vy_q, gx_q, gy_q;
  logic                         drag_q;
  logic signed [MOUSE_BITS-1:0] pmx_q, pmy_q;

  // current item
  logic [FT_W-1:0]              dt_q;
  logic signed [MOUSE_BITS-1:0] mx_q, my_q;
  logic                         press_q, rel_q;

  // hit test scratch
  logic [BW-1:0] ay_q;
  wide_t         sq_q;

  state_e state_q, state_d, ret_q, ret_d;

  logic                 mul_start, mul_done;
  logic signed [AW-1:0] mul_a;
  logic [BW-1:0]        mul_b;
  logic signed [PW-1:0] prod;

  logic                 m_valid_q, m_held_q;
  logic [127:0]         m_data_q;

  logic  in_acc, out_load;
  wide_t mfx, mfy, r_fix, wfx, hfy, dx, dy, adx, ady, rp, grav, dmx, dmy;
  logic  hit_far, hi_x, lo_x, hi_y, lo_y, in_ball;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  assign mfx   = wide_t'(mx_q) <<< FRAC_BITS;
  assign mfy   = wide_t'(my_q) <<< FRAC_BITS;
  assign r_fix = wide_t'({1'b0, radius_q}) <<< FRAC_BITS;
  assign wfx   = wide_t'({1'b0, width_q}) <<< FRAC_BITS;
  assign hfy   = wide_t'({1'b0, height_q}) <<< FRAC_BITS;
  assign grav  = wide_t'(50) <<< FRAC_BITS;

  assign dx  = wide_t'(cx_q) - mfx;
  assign dy  = wide_t'(cy_q) - mfy;
  assign adx = (dx < 0) ? -dx : dx;
  assign ady = (dy < 0) ? -dy : dy;
  assign hit_far = (adx > r_fix) || (ady > r_fix);
  assign in_ball = (sq_q <= wide_t'(prod));

  assign rp = rnd16(prod);

  // wall tests on the registered positions
  assign hi_x = (wide_t'(cx_q) + r_fix) >= wfx;
  assign lo_x = (wide_t'(cx_q) - r_fix) <= 0;
  assign hi_y = (wide_t'(cy_q) + r_fix) >= hfy;
  assign lo_y = (wide_t'(cy_q) - r_fix) <= 0;

  // pointer motion, times 50 = 32 + 16 + 2
  assign dmx = wide_t'(mx_q) - wide_t'(pmx_q);
  assign dmy = wide_t'(my_q) - wide_t'(pmy_q);

  bbms_sermul #(.AW(AW), .BW(BW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  always_comb begin
    wide_t nv;
    state_d   = state_q;
    ret_d     = ret_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    nv        = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = s_axis_tuser[0] ? ST_HIT : ST_BRANCH;
        end
      end
      ST_HIT: begin
        if (hit_far) begin
          state_d = ST_BRANCH;
        end else begin
          mul_start = 1'b1;
          mul_a     = AW'({1'b0, adx[BW-1:0]});
          mul_b     = adx[BW-1:0];
          ret_d     = ST_SQY;
          state_d   = ST_WAIT;
        end
      end
      ST_SQY: begin
        mul_start = 1'b1;
        mul_a     = AW'({1'b0, ay_q});
        mul_b     = ay_q;
        ret_d     = ST_SQR;
        state_d   = ST_WAIT;
      end
      ST_SQR: begin
        mul_start = 1'b1;
        mul_a     = AW'({1'b0, r_fix[BW-1:0]});
        mul_b     = r_fix[BW-1:0];
        ret_d     = ST_HITDEC;
        state_d   = ST_WAIT;
      end
      ST_HITDEC: state_d = ST_BRANCH;
      ST_BRANCH: state_d = drag_q ? ST_DRAG : ST_MOVE;
      ST_DRAG:   state_d = ST_OUT;
      ST_MOVE: begin
        mul_start = 1'b1;
        mul_a     = AW'(vx_q);
        mul_b     = BW'(dt_q);
        ret_d     = ST_MVY;
        state_d   = ST_WAIT;
      end
      ST_MVY: begin
        mul_start = 1'b1;
        mul_a     = AW'(vy_q);
        mul_b     = BW'(dt_q);
        ret_d     = ST_WX;
        state_d   = ST_WAIT;
      end
      ST_WX: begin
        if (hi_x || lo_x) begin
          nv        = -wide_t'(vx_q);
          mul_start = 1'b1;
          mul_a     = nv[AW-1:0];
          mul_b     = BW'(bounce_q);
          ret_d     = ST_WXB;
          state_d   = ST_WAIT;
        end else begin
          state_d = ST_WY;
        end
      end
      ST_WXB: state_d = ST_WY;
      ST_WY: begin
        if (hi_y || lo_y) begin
          nv        = -wide_t'(vy_q);
          mul_start = 1'b1;
          mul_a     = nv[AW-1:0];
          mul_b     = BW'(bounce_q);
          ret_d     = ST_WYB;
          state_d   = ST_WAIT;
        end else begin
          state_d = ST_FX;
        end
      end
      ST_WYB: state_d = ST_FX;
      ST_FX: begin
        mul_start = 1'b1;
        mul_a     = AW'(vx_q);
        mul_b     = BW'(fric_q);
        ret_d     = ST_FY;
        state_d   = ST_WAIT;
      end
      ST_FY: begin
        mul_start = 1'b1;
        mul_a     = AW'(vy_q);
        mul_b     = BW'(fric_q);
        ret_d     = ST_FIN;
        state_d   = ST_WAIT;
      end
      ST_FIN: state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (mul_done) begin
          state_d = ret_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // config port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SCR_W'(800);
      height_q <= SCR_W'(600);
      radius_q <= RAD_W'(50);
      fric_q   <= FAC_W'(64881);
      bounce_q <= FAC_W'(58982);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i[SCR_W-1:0];
        CFG_SCREEN_HEIGHT: height_q <= cfg_data_i[SCR_W-1:0];
        CFG_BALL_RADIUS:   radius_q <= cfg_data_i[RAD_W-1:0];
        CFG_FRICTION:      fric_q   <= cfg_data_i[FAC_W-1:0];
        CFG_BOUNCE:        bounce_q <= cfg_data_i[FAC_W-1:0];
        default: ;
      endcase
    end
  end

  // ball state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= sat32(wide_t'(400) <<< FRAC_BITS);
      cy_q   <= sat32(wide_t'(300) <<< FRAC_BITS);
      vx_q   <= sat32(wide_t'(300) <<< FRAC_BITS);
      vy_q   <= sat32(wide_t'(300) <<< FRAC_BITS);
      drag_q <= 1'b0;
      gx_q   <= '0;
      gy_q   <= '0;
      pmx_q  <= '0;
      pmy_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          // release alone ends a drag; a press is settled by the hit test
          if (in_acc && !s_axis_tuser[0] && s_axis_tuser[1]) begin
            drag_q <= 1'b0;
          end
        end
        ST_HITDEC: begin
          if (in_ball) begin
            drag_q <= 1'b1;
            gx_q   <= sat32(mfx - wide_t'(cx_q));
            gy_q   <= sat32(mfy - wide_t'(cy_q));
          end
        end
        ST_DRAG: begin
          cx_q  <= sat32(mfx - wide_t'(gx_q));
          cy_q  <= sat32(mfy - wide_t'(gy_q));
          vx_q  <= sat32(((dmx <<< 5) + (dmx <<< 4) + (dmx <<< 1)) <<< FRAC_BITS);
          vy_q  <= sat32(((dmy <<< 5) + (dmy <<< 4) + (dmy <<< 1)) <<< FRAC_BITS);
          pmx_q <= mx_q;
          pmy_q <= my_q;
        end
        ST_MVY: cx_q <= sat32(wide_t'(cx_q) + rp);
        ST_WX: begin
          cy_q <= sat32(wide_t'(cy_q) + rp);
          if (hi_x) begin
            cx_q <= sat32(wfx - r_fix);
          end else if (lo_x) begin
            cx_q <= sat32(r_fix);
          end
        end
        ST_WXB: vx_q <= sat32(rp);
        ST_WY: begin
          if (hi_y) begin
            cy_q <= sat32(hfy - r_fix);
          end else if (lo_y) begin
            cy_q <= sat32(r_fix);
          end
        end
        ST_WYB: vy_q <= sat32(rp);
        ST_FY:  vx_q <= sat32(rp);
        ST_FIN: vy_q <= sat32(wide_t'(sat32(rp)) + grav);
        default: ;
      endcase
    end
  end

  // item capture and hit-test scratch
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dt_q    <= s_axis_tdata[FT_W-1:0];
      mx_q    <= signed'(s_axis_tdata[FT_W +: MOUSE_BITS]);
      my_q    <= signed'(s_axis_tdata[FT_W+MOUSE_W +: MOUSE_BITS]);
      press_q <= s_axis_tuser[0];
      rel_q   <= s_axis_tuser[1];
    end
    if (state_q == ST_HIT) begin
      ay_q <= ady[BW-1:0];
    end
    if (state_q == ST_SQY) begin
      sq_q <= wide_t'(prod);
    end
    if (state_q == ST_SQR) begin
      sq_q <= sq_q + wide_t'(prod);
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {vy_q, vx_q, cy_q, cx_q};
      // press and release flags of the item travel no further
      m_held_q <= drag_q | (press_q & rel_q & drag_q);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_held_q;

  `BB_ASSERT_NXT(a_ret_after_done, mul_done, state_q == $past(ret_q), "no return after product")
  `BB_ASSERT_IMP(a_out_from_seq, $rose(m_valid_q), $past(state_q == ST_OUT), "result not from end")

endmodule

### sv/bbms_sermul.sv
`include "assert_macros.svh"

// Shift-add multiplier: signed a times unsigned b, one bit of b per cycle.
// Stops as soon as the remaining multiplier bits are zero.
module bbms_sermul #(
  parameter int AW = 36,
  parameter int BW = 27
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic        [BW-1:0]    b_i,
  output logic                    done_o,
  output logic signed [AW+BW-1:0] prod_o
);

  localparam int PW = AW + BW;

  logic signed [PW-1:0] acc_q, ash_q;
  logic        [BW-1:0] bsh_q;
  logic                 busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && (bsh_q == '0)) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      ash_q <= PW'(a_i);
      bsh_q <= b_i;
    end else if (busy_q && (bsh_q != '0)) begin
      if (bsh_q[0]) begin
        acc_q <= acc_q + ash_q;
      end
      ash_q <= ash_q <<< 1;
      bsh_q <= bsh_q >> 1;
    end
  end

  assign done_o = busy_q && (bsh_q == '0);
  assign prod_o = acc_q;

  `BB_ASSERT_IMP(a_no_restart, start_i, !busy_q, "multiplier restarted while busy")
  `BB_ASSERT_NXT(a_done_ends, done_o, !busy_q, "multiplier still busy after done")

endmodule
